@@ rtl/assert_macros.svh @@
// Assertion macros used by the monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of clk while reset is released.
`define MAT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also active while reset is asserted.
`define MAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mat_pkg.sv @@
`default_nettype none

package mat_pkg;

    localparam int unsigned AXES = 3;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned TOTAL_W = 32;
    localparam int unsigned SAMPLE_PERIOD_MS_DEFAULT = 10;

    localparam logic [15:0] THRESHOLD_RESET = 16'd2000;
    localparam logic [31:0] TIMEOUT_LIMIT_RESET = 32'd60000;

    typedef enum logic [1:0] {
        REG_THRESHOLD_X = 2'd0,
        REG_THRESHOLD_Y = 2'd1,
        REG_THRESHOLD_Z = 2'd2,
        REG_TIMEOUT_LIMIT = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic opcode;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic [31:0] activity_total;
        logic moving;
        logic timeout_reached;
    } result_t;

    typedef struct packed {
        cfg_index_t index;
        logic [31:0] wdata;
    } cfg_write_t;

endpackage

`default_nettype wire

@@ rtl/mat_if.sv @@
`default_nettype none

interface mat_in_if;
    logic valid;
    logic ready;
    mat_pkg::sample_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mat_out_if;
    logic valid;
    logic ready;
    mat_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mat_cfg_if;
    logic valid;
    logic ready;
    mat_pkg::cfg_write_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/motion_activity_timeout_monitor.sv @@
// Motion activity and timeout monitor. Each sample request carries three signed accelerometer
// axes; for every axis whose absolute change from the previous sample exceeds its threshold,
// the quotient change/threshold is added to a saturating 32-bit activity total and the sample
// counts as moving. The still-time counter clears when two consecutive samples move and
// otherwise advances by SAMPLE_PERIOD_MS, flagging a timeout at or above timeout_limit_ms.
// A clear request zeroes the total and returns an all-zero result. One shared restoring
// divider produces one quotient bit per cycle; each axis is loaded in turn, and each moving
// one is divided and accumulated. A clear request goes straight to done. The block accepts
// no request while one is in work, but a finished result may wait in the output register
// while the next request is taken. Thresholds of 0 act as 1.
// Configuration writes are always accepted and must only be issued while the block is idle.

`default_nettype none

`include "assert_macros.svh"

module motion_activity_timeout_monitor #(
    parameter int unsigned SAMPLE_PERIOD_MS = mat_pkg::SAMPLE_PERIOD_MS_DEFAULT
) (
    input wire logic clk,
    input wire logic rst_n,
    mat_in_if.sink sample,
    mat_out_if.source result,
    mat_cfg_if.sink cfg
);

    mat_pkg::state_t state_reg;
    mat_pkg::state_t state_next;

    logic [15:0] thr_reg [mat_pkg::AXES];
    logic [31:0] limit_reg;

    logic [15:0] prev_reg [mat_pkg::AXES];
    logic [15:0] samp_reg [mat_pkg::AXES];
    logic prev_moving_reg;
    logic [31:0] still_reg;
    logic [31:0] activity_reg;

    logic [1:0] ax_reg;
    logic [3:0] cnt_reg;
    logic mov_reg;
    logic clr_reg;

    logic [15:0] div_reg;
    logic [15:0] rem_reg;
    logic [15:0] quo_reg;

    logic out_valid_reg;
    mat_pkg::result_t out_data_reg;

    logic in_ready;
    logic out_load;
    logic last_axis;

    logic [16:0] diff;
    logic [16:0] diff_abs;
    logic [15:0] mag;
    logic [15:0] thr_eff;
    logic axis_moved;

    logic [16:0] shifted;
    logic div_ge;
    logic [32:0] act_sum;
    logic [31:0] act_sat;
    logic [32:0] still_sum;
    logic [31:0] still_sat;
    logic hold_clear;
    logic [31:0] still_new;
    logic timeout_new;

    assign last_axis = (ax_reg == 2'(mat_pkg::AXES - 1));

    // Shared per-axis front end: absolute change and effective threshold.
    always_comb
    begin
        diff = {samp_reg[ax_reg][15], samp_reg[ax_reg]} - {prev_reg[ax_reg][15], prev_reg[ax_reg]};
        diff_abs = diff[16] ? (17'd0 - diff) : diff;
        mag = diff_abs[15:0];
        thr_eff = (thr_reg[ax_reg] == 16'd0) ? 16'd1 : thr_reg[ax_reg];
        axis_moved = (mag > thr_eff);
    end

    // Shared restoring divider step and saturating adders.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[15]};
        div_ge = (shifted >= {1'b0, div_reg});
        act_sum = {1'b0, activity_reg} + {17'd0, quo_reg};
        act_sat = act_sum[32] ? 32'hFFFF_FFFF : act_sum[31:0];
        still_sum = {1'b0, still_reg} + 33'(SAMPLE_PERIOD_MS);
        still_sat = still_sum[32] ? 32'hFFFF_FFFF : still_sum[31:0];
        hold_clear = mov_reg && prev_moving_reg;
        still_new = hold_clear ? 32'd0 : still_sat;
        timeout_new = !hold_clear && (still_sat >= limit_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mat_pkg::ST_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = (sample.data.opcode == mat_pkg::OP_CLEAR) ?
                        mat_pkg::ST_DONE : mat_pkg::ST_LOAD;
                end
            end
            mat_pkg::ST_LOAD:
            begin
                if (axis_moved)
                begin
                    state_next = mat_pkg::ST_DIV;
                end
                else if (last_axis)
                begin
                    state_next = mat_pkg::ST_DONE;
                end
            end
            mat_pkg::ST_DIV:
            begin
                if (cnt_reg == 4'd0)
                begin
                    state_next = mat_pkg::ST_ACC;
                end
            end
            mat_pkg::ST_ACC:
            begin
                state_next = last_axis ? mat_pkg::ST_DONE : mat_pkg::ST_LOAD;
            end
            mat_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = mat_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mat_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            mat_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            mat_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || result.ready;
            end
            default:
            begin
                in_ready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign sample.ready = in_ready;
    assign cfg.ready = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mat_pkg::ST_IDLE;
            for (int i = 0; i < int'(mat_pkg::AXES); i++)
            begin
                thr_reg[i] <= mat_pkg::THRESHOLD_RESET;
                prev_reg[i] <= 16'd0;
            end
            limit_reg <= mat_pkg::TIMEOUT_LIMIT_RESET;
            prev_moving_reg <= 1'b0;
            still_reg <= 32'd0;
            activity_reg <= 32'd0;
            ax_reg <= 2'd0;
            cnt_reg <= 4'd0;
            mov_reg <= 1'b0;
            clr_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                case (cfg.data.index)
                    mat_pkg::REG_THRESHOLD_X: thr_reg[0] <= cfg.data.wdata[15:0];
                    mat_pkg::REG_THRESHOLD_Y: thr_reg[1] <= cfg.data.wdata[15:0];
                    mat_pkg::REG_THRESHOLD_Z: thr_reg[2] <= cfg.data.wdata[15:0];
                    mat_pkg::REG_TIMEOUT_LIMIT: limit_reg <= cfg.data.wdata;
                    default: limit_reg <= limit_reg;
                endcase
            end

            case (state_reg)
                mat_pkg::ST_IDLE:
                begin
                    if (sample.valid)
                    begin
                        ax_reg <= 2'd0;
                        mov_reg <= 1'b0;
                        clr_reg <= (sample.data.opcode == mat_pkg::OP_CLEAR);
                    end
                end
                mat_pkg::ST_LOAD:
                begin
                    if (axis_moved)
                    begin
                        mov_reg <= 1'b1;
                        cnt_reg <= 4'd15;
                    end
                    else if (!last_axis)
                    begin
                        ax_reg <= ax_reg + 2'd1;
                    end
                end
                mat_pkg::ST_DIV:
                begin
                    cnt_reg <= cnt_reg - 4'd1;
                end
                mat_pkg::ST_ACC:
                begin
                    activity_reg <= act_sat;
                    if (!last_axis)
                    begin
                        ax_reg <= ax_reg + 2'd1;
                    end
                end
                mat_pkg::ST_DONE:
                begin
                    if (out_load)
                    begin
                        if (clr_reg)
                        begin
                            activity_reg <= 32'd0;
                        end
                        else
                        begin
                            still_reg <= still_new;
                            prev_moving_reg <= mov_reg;
                            for (int i = 0; i < int'(mat_pkg::AXES); i++)
                            begin
                                prev_reg[i] <= samp_reg[i];
                            end
                        end
                    end
                end
                default:
                begin
                    ax_reg <= 2'd0;
                end
            endcase

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mat_pkg::ST_IDLE && sample.valid)
        begin
            samp_reg[0] <= sample.data.accel_x;
            samp_reg[1] <= sample.data.accel_y;
            samp_reg[2] <= sample.data.accel_z;
        end

        if (state_reg == mat_pkg::ST_LOAD)
        begin
            div_reg <= thr_eff;
            rem_reg <= 16'd0;
            quo_reg <= mag;
        end
        else if (state_reg == mat_pkg::ST_DIV)
        begin
            rem_reg <= div_ge ? 16'(shifted - {1'b0, div_reg}) : shifted[15:0];
            quo_reg <= {quo_reg[14:0], div_ge};
        end

        if (out_load)
        begin
            if (clr_reg)
            begin
                out_data_reg.activity_total <= 32'd0;
                out_data_reg.moving <= 1'b0;
                out_data_reg.timeout_reached <= 1'b0;
            end
            else
            begin
                out_data_reg.activity_total <= activity_reg;
                out_data_reg.moving <= mov_reg;
                out_data_reg.timeout_reached <= timeout_new;
            end
        end
    end

    `MAT_ASSERT(a_accept_leaves_idle, clk, rst_n,
        (sample.valid && sample.ready) |=> (state_reg != mat_pkg::ST_IDLE),
        "accepted request did not start work")
    `MAT_ASSERT(a_acc_after_div, clk, rst_n,
        (state_reg == mat_pkg::ST_ACC) |-> ($past(state_reg) == mat_pkg::ST_DIV),
        "activity update without a completed division")
    `MAT_ASSERT(a_clear_zeroes_total, clk, rst_n,
        (out_load && clr_reg) |=> (activity_reg == 32'd0),
        "clear request left a nonzero activity total")

endmodule

`default_nettype wire

@@ verif/tb_motion_activity_timeout_monitor.sv @@
module tb_motion_activity_timeout_monitor;

    localparam int unsigned PERIOD_MS = mat_pkg::SAMPLE_PERIOD_MS_DEFAULT;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned ITEMS_PER_PHASE = 200;
    localparam int unsigned REPORT_LIMIT = 10;

    logic clk;
    logic rst_n;

    mat_in_if sample_if ();
    mat_out_if result_if ();
    mat_cfg_if cfg_if ();

    motion_activity_timeout_monitor #(
        .SAMPLE_PERIOD_MS(PERIOD_MS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample_if),
        .result(result_if),
        .cfg(cfg_if)
    );

    logic [15:0] model_thr [mat_pkg::AXES];
    logic [31:0] model_limit;
    logic [15:0] model_prev [mat_pkg::AXES];
    logic model_prev_moving;
    logic [31:0] model_still_ms;
    logic [31:0] model_total;

    mat_pkg::result_t expected_results [$];
    logic [15:0] stim_prev [mat_pkg::AXES];

    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned sink_stall_left;
    bit src_idle_en;
    bit sink_idle_en;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [31:0] add_saturate(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic mat_pkg::result_t predict_result(mat_pkg::sample_t s);
        mat_pkg::result_t r;
        logic [15:0] now [mat_pkg::AXES];
        int diff;
        int unsigned mag;
        int unsigned divisor;
        logic moved;
        r = '0;
        if (s.opcode == mat_pkg::OP_CLEAR)
        begin
            model_total = '0;
            return r;
        end
        now[0] = s.accel_x;
        now[1] = s.accel_y;
        now[2] = s.accel_z;
        moved = 1'b0;
        for (int a = 0; a < mat_pkg::AXES; a++)
        begin
            diff = int'($signed(now[a])) - int'($signed(model_prev[a]));
            mag = (diff < 0) ? -diff : diff;
            divisor = (model_thr[a] == 16'd0) ? 1 : model_thr[a];
            if (mag > divisor)
            begin
                model_total = add_saturate(model_total, mag / divisor);
                moved = 1'b1;
            end
        end
        if (moved && model_prev_moving)
        begin
            model_still_ms = '0;
        end
        else
        begin
            model_still_ms = add_saturate(model_still_ms, PERIOD_MS);
            r.timeout_reached = (model_still_ms >= model_limit);
        end
        model_prev_moving = moved;
        model_prev = now;
        r.activity_total = model_total;
        r.moving = moved;
        return r;
    endfunction

    always @(posedge clk)
    begin
        mat_pkg::result_t expected;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("unexpected result: total %0d moving %0b timeout %0b",
                                 result_if.data.activity_total, result_if.data.moving,
                                 result_if.data.timeout_reached);
                    mismatch_count++;
                end
                else
                begin
                    expected = expected_results.pop_front();
                    if (result_if.data.activity_total !== expected.activity_total ||
                        result_if.data.moving !== expected.moving ||
                        result_if.data.timeout_reached !== expected.timeout_reached)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("exp total %0d mov %0b tmo %0b, got total %0d mov %0b tmo %0b",
                                     expected.activity_total, expected.moving,
                                     expected.timeout_reached, result_if.data.activity_total,
                                     result_if.data.moving, result_if.data.timeout_reached);
                        mismatch_count++;
                    end
                end
            end
            if (sample_if.valid && sample_if.ready)
                expected_results.push_back(predict_result(sample_if.data));
            if (cfg_if.valid && cfg_if.ready)
            begin
                case (cfg_if.data.index)
                    mat_pkg::REG_THRESHOLD_X: model_thr[0] = cfg_if.data.wdata[15:0];
                    mat_pkg::REG_THRESHOLD_Y: model_thr[1] = cfg_if.data.wdata[15:0];
                    mat_pkg::REG_THRESHOLD_Z: model_thr[2] = cfg_if.data.wdata[15:0];
                    mat_pkg::REG_TIMEOUT_LIMIT: model_limit = cfg_if.data.wdata;
                    default: ;
                endcase
            end
        end
    end

    always @(negedge clk)
    begin
        if (sink_idle_en && sink_stall_left > 0)
        begin
            sink_stall_left--;
            result_if.ready <= 1'b0;
        end
        else if (sink_idle_en && $urandom_range(0, 5) == 0)
        begin
            sink_stall_left = $urandom_range(0, 11);
            result_if.ready <= 1'b0;
        end
        else
        begin
            result_if.ready <= 1'b1;
        end
    end

    task automatic send_request(mat_pkg::opcode_t op, logic [15:0] x, logic [15:0] y,
                                logic [15:0] z);
        int unsigned gap;
        gap = (src_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_if.valid <= 1'b1;
        sample_if.data <= '{opcode: op, accel_x: x, accel_y: y, accel_z: z};
        do @(posedge clk); while (!sample_if.ready);
        if (op == mat_pkg::OP_SAMPLE)
            stim_prev = '{x, y, z};
    endtask

    task automatic wait_idle();
        @(negedge clk);
        sample_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(mat_pkg::cfg_index_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= '{index: idx, wdata: value};
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic write_config(logic [15:0] thr_x, logic [15:0] thr_y, logic [15:0] thr_z,
                                logic [31:0] limit_ms);
        wait_idle();
        write_register(mat_pkg::REG_THRESHOLD_X, {16'd0, thr_x});
        write_register(mat_pkg::REG_THRESHOLD_Y, {16'd0, thr_y});
        write_register(mat_pkg::REG_THRESHOLD_Z, {16'd0, thr_z});
        write_register(mat_pkg::REG_TIMEOUT_LIMIT, limit_ms);
    endtask

    function automatic logic [15:0] random_threshold();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd1;
            3: return 16'($urandom);
            default: return 16'($urandom_range(2, 5000));
        endcase
    endfunction

    function automatic logic [31:0] random_limit();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return PERIOD_MS * $urandom_range(1, 40);
        endcase
    endfunction

    function automatic logic [15:0] next_axis(logic [15:0] prev, logic [15:0] thr_reg);
        int t;
        int delta;
        int v;
        t = (thr_reg == 16'd0) ? 1 : thr_reg;
        case ($urandom_range(0, 7))
            0: delta = 0;
            1: delta = int'($urandom_range(0, 2 * t)) - t;
            2: delta = t;
            3: delta = t + 1;
            4: delta = -t;
            5: delta = -(t + 1);
            6: delta = int'($urandom_range(2, 40)) * t + int'($urandom_range(0, t - 1));
            default: return 16'($urandom);
        endcase
        v = int'($signed(prev)) + delta;
        if (v > 32767 || v < -32768)
            v = int'($signed(prev)) - delta;
        if (v > 32767 || v < -32768)
            return 16'($urandom);
        return 16'(v);
    endfunction

    task automatic test_default_config();
        send_request(mat_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
        send_request(mat_pkg::OP_SAMPLE, 16'h7FFF, 16'h0000, 16'h0000);
        send_request(mat_pkg::OP_SAMPLE, 16'h8000, 16'd2001, 16'hF82F);
        send_request(mat_pkg::OP_SAMPLE, 16'h8000, 16'd2001, 16'hF82F);
        send_request(mat_pkg::OP_SAMPLE, 16'h8000, 16'd4001, 16'hF82F);
        send_request(mat_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(mat_pkg::OP_SAMPLE, 16'h8000, 16'd4001, 16'h7FFF);
    endtask

    task automatic test_register_extremes();
        // A zero threshold behaves as one, and a zero limit flags every still request.
        write_config(16'd0, 16'd0, 16'd0, 32'd0);
        send_request(mat_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
        send_request(mat_pkg::OP_SAMPLE, 16'h0001, 16'h0000, 16'h0000);
        send_request(mat_pkg::OP_SAMPLE, 16'h0003, 16'h0000, 16'h0000);
        send_request(mat_pkg::OP_SAMPLE, 16'h0005, 16'h0002, 16'hFFFE);
        write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(mat_pkg::OP_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
        send_request(mat_pkg::OP_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        write_config(16'hFFFE, 16'hFFFE, 16'hFFFE, 32'hFFFF_FFF6);
        send_request(mat_pkg::OP_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
    endtask

    task automatic test_clear_requests();
        write_config(mat_pkg::THRESHOLD_RESET, mat_pkg::THRESHOLD_RESET,
                     mat_pkg::THRESHOLD_RESET, 32'd30);
        send_request(mat_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
        send_request(mat_pkg::OP_CLEAR, 16'h1234, 16'h8000, 16'h7FFF);
        send_request(mat_pkg::OP_SAMPLE, 16'h7FFF, 16'h0000, 16'h0000);
        send_request(mat_pkg::OP_CLEAR, 16'h0000, 16'h0000, 16'h0000);
        send_request(mat_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(mat_pkg::OP_SAMPLE, 16'h7FFF, 16'h0000, 16'h0000);
        send_request(mat_pkg::OP_SAMPLE, 16'h7FFF, 16'h0000, 16'h0000);
        send_request(mat_pkg::OP_SAMPLE, 16'h7FFF, 16'h0000, 16'h0000);
    endtask

    task automatic test_random_settings();
        int unsigned pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == RANDOM_PHASES - 1)
            begin
                src_idle_en = 1'b0;
                sink_idle_en = 1'b0;
            end
            write_config(random_threshold(), random_threshold(), random_threshold(),
                         random_limit());
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase != RANDOM_PHASES - 1 && n % 40 == 0)
                begin
                    src_idle_en = ($urandom_range(0, 3) != 0);
                    sink_idle_en = ($urandom_range(0, 3) != 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    send_request(mat_pkg::OP_CLEAR, 16'($urandom), 16'($urandom),
                                 16'($urandom));
                else if (pick < 20)
                    send_request(mat_pkg::OP_SAMPLE, 16'($urandom), 16'($urandom),
                                 16'($urandom));
                else if (pick < 40)
                    send_request(mat_pkg::OP_SAMPLE, stim_prev[0], stim_prev[1],
                                 stim_prev[2]);
                else
                    send_request(mat_pkg::OP_SAMPLE, next_axis(stim_prev[0], model_thr[0]),
                                 next_axis(stim_prev[1], model_thr[1]),
                                 next_axis(stim_prev[2], model_thr[2]));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        sample_if.valid = 1'b0;
        sample_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        result_if.ready = 1'b0;
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        sink_stall_left = 0;
        mismatch_count = 0;
        cycle_count = 0;
        model_thr = '{mat_pkg::THRESHOLD_RESET, mat_pkg::THRESHOLD_RESET,
                      mat_pkg::THRESHOLD_RESET};
        model_limit = mat_pkg::TIMEOUT_LIMIT_RESET;
        model_prev = '{16'd0, 16'd0, 16'd0};
        model_prev_moving = 1'b0;
        model_still_ms = '0;
        model_total = '0;
        stim_prev = '{16'd0, 16'd0, 16'd0};
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        test_default_config();
        test_register_extremes();
        test_clear_requests();
        test_random_settings();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mat_pkg.sv
rtl/mat_if.sv
rtl/motion_activity_timeout_monitor.sv
verif/tb_motion_activity_timeout_monitor.sv
